@@ sv/cdes_pkg.sv @@
`timescale 1ns / 1ps

package cdes_pkg;

  localparam int unsigned BaseYear    = 2000;
  // Leap years in 1..1999 by the Gregorian rule
  localparam int unsigned LeapsBefore = 484;
  localparam int unsigned DaysPerYear = 365;
  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;

  // floor(x / 100) == (x * Recip100) >> Recip100Shift, exact for x below 43690
  localparam int unsigned Recip100      = 5243;
  localparam int unsigned Recip100Shift = 19;

  localparam int unsigned MonthFirst = 1;
  localparam int unsigned MonthFeb   = 2;
  localparam int unsigned MonthLast  = 12;

  // Days before the first of the given month in a common year
  function automatic logic [8:0] month_start(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

@@ sv/calendar_date_to_epoch_seconds.sv @@
`timescale 1ns / 1ps

// Converts a broken-down Gregorian date and time of day into seconds since
// 2000-01-01 00:00:00, wrapping modulo 2^32.
//
// Input channel: year, month, day, hour, minute, second with in_valid and
// in_ready. Output channel: epoch_seconds with out_valid and out_ready.
// A beat moves when valid and ready are both high at a rising edge.
//
// Four register stages: reciprocal products and time of day, leap counts and
// year days, day sum, then days times 86400 into the output register. One
// beat is taken per cycle while the output is not stalled. An accepted beat
// passes through stage 1, stage 2 and stage 3 to the output register, where
// out_valid rises. Throughput is one conversion per cycle unless stalled.
//
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline holds and in_ready drops; nothing is lost or repeated. Stages that
// carry bubbles still hold during a stall.
//
// Synchronous reset clears all stage valid bits; the block is ready for input
// as soon as reset is released.
module calendar_date_to_epoch_seconds (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  input  logic [4:0]  hour,
  input  logic [5:0]  minute,
  input  logic [5:0]  second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] epoch_seconds
);

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1
  logic        v1;
  logic [24:0] s1_px;
  logic [22:0] s1_pq;
  logic [24:0] s1_py;
  logic [11:0] s1_year;
  logic [9:0]  s1_q4;
  logic        s1_gt;
  logic [11:0] s1_n;
  logic [8:0]  s1_mdays;
  logic        s1_late;
  logic [4:0]  s1_dm1;
  logic [16:0] s1_tod;

  logic [11:0] xm1;
  logic        mvalid;
  assign xm1    = year - 12'd1;
  assign mvalid = (month >= 4'(cdes_pkg::MonthFirst)) && (month <= 4'(cdes_pkg::MonthLast));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      s1_px    <= 25'(xm1) * 25'(cdes_pkg::Recip100);
      s1_pq    <= 23'(xm1[11:2]) * 23'(cdes_pkg::Recip100);
      s1_py    <= 25'(year) * 25'(cdes_pkg::Recip100);
      s1_year  <= year;
      s1_q4    <= xm1[11:2];
      s1_gt    <= year > 12'(cdes_pkg::BaseYear);
      s1_n     <= year - 12'(cdes_pkg::BaseYear);
      s1_mdays <= mvalid ? cdes_pkg::month_start(month) : 9'd0;
      s1_late  <= mvalid && (month > 4'(cdes_pkg::MonthFeb));
      s1_dm1   <= (day != 5'd0) ? day - 5'd1 : 5'd0;
      s1_tod   <= 17'(hour) * 17'(cdes_pkg::SecsPerHour)
                + 17'(minute) * 17'(cdes_pkg::SecsPerMin)
                + 17'(second);
    end
  end

  // Stage 2
  localparam int unsigned Sh = cdes_pkg::Recip100Shift;

  logic        v2;
  logic [20:0] s2_n365;
  logic [9:0]  s2_leaps;
  logic        s2_gt;
  logic [8:0]  s2_mdays;
  logic [4:0]  s2_dm1;
  logic [16:0] s2_tod;

  logic [5:0]  q100;
  logic [3:0]  q400;
  logic [5:0]  qy100;
  logic [10:0] leaps_full;
  logic [11:0] ry;
  logic        leap;

  assign q100       = s1_px[Sh+5:Sh];
  assign q400       = s1_pq[Sh+3:Sh];
  assign qy100      = s1_py[Sh+5:Sh];
  // Only meaningful above the base year, where it stays non-negative
  assign leaps_full = 11'(s1_q4) - 11'(q100) + 11'(q400) - 11'(cdes_pkg::LeapsBefore);
  assign ry         = s1_year - 12'(qy100) * 12'd100;
  // Divisible by 400 means remainder 0 and a century count divisible by 4
  assign leap       = (s1_year[1:0] == 2'b00) && ((ry != 12'd0) || (qy100[1:0] == 2'b00));

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      s2_n365  <= 21'(s1_n) * 21'(cdes_pkg::DaysPerYear);
      s2_leaps <= leaps_full[9:0];
      s2_gt    <= s1_gt;
      s2_mdays <= s1_mdays + 9'(s1_late && leap);
      s2_dm1   <= s1_dm1;
      s2_tod   <= s1_tod;
    end
  end

  // Stage 3
  logic        v3;
  logic [19:0] s3_days;
  logic [16:0] s3_tod;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      s3_days <= (s2_gt ? 20'(s2_n365) + 20'(s2_leaps) : 20'd0)
               + 20'(s2_mdays) + 20'(s2_dm1);
      s3_tod  <= s2_tod;
    end
  end

  // Output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v3;
    end
    if (adv) begin
      epoch_seconds <= 32'(s3_days) * 32'(cdes_pkg::SecsPerDay) + 32'(s3_tod);
    end
  end

  // An accepted beat reaches the output when the pipeline keeps advancing through stage 2, stage 3 and the output stage
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 in_ready ##1 in_ready ##1 in_ready |=> out_valid)
    else $error("accepted beat did not reach the output");

  // A result cannot appear unless the pipeline advanced
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_ready))
    else $error("result appeared while the pipeline was held");

  assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !v1 && !v2 && !v3)
    else $error("pipeline not empty after reset");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned EpochYear   = 2000;
  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned SettleTail  = 24;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] epoch_seconds;

  logic [31:0] epoch_due[$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  bit          idle_en;

  calendar_date_to_epoch_seconds dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .year         (year),
    .month        (month),
    .day          (day),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .epoch_seconds(epoch_seconds)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_len(input int unsigned m, input int unsigned y);
    case (m)
      4, 6, 9, 11: return 30;
      2:           return is_leap(y) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  // Leap years counted in 1..x
  function automatic longint unsigned leaps_upto(input int unsigned x);
    return x / 4 - x / 100 + x / 400;
  endfunction

  function automatic logic [31:0] epoch_of(input logic [11:0] y, input logic [3:0] mo,
                                           input logic [4:0] d, input logic [4:0] h,
                                           input logic [5:0] mi, input logic [5:0] s);
    longint unsigned days;
    longint unsigned total;
    int unsigned     yr;
    yr   = y;
    days = 0;
    if (yr > EpochYear)
      days = longint'(yr - EpochYear) * 365 + leaps_upto(yr - 1) - leaps_upto(EpochYear - 1);
    // Walk whole months; February picks up the leap day by itself
    if (mo >= 1 && mo <= 12) begin
      for (int m = 1; m < mo; m++) days += month_len(m, yr);
    end
    if (d != 0) days += d - 1;
    total = days * 86400 + longint'(h) * 3600 + longint'(mi) * 60 + longint'(s);
    return total[31:0];
  endfunction

  // With idle_en, sometimes idle first; present one beat and hold it until taken; valid stays high on exit
  task automatic send_date(input logic [11:0] y, input logic [3:0] mo, input logic [4:0] d,
                           input logic [4:0] h, input logic [5:0] mi, input logic [5:0] s);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    year     <= y;
    month    <= mo;
    day      <= d;
    hour     <= h;
    minute   <= mi;
    second   <= s;
    do @(posedge clk); while (!in_ready);
    epoch_due.push_back(epoch_of(y, mo, d, h, mi, s));
  endtask

  task automatic drop_valid;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained;
    while (epoch_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_date(input bit well_formed);
    int unsigned y;
    int unsigned mo;
    if (!well_formed) begin
      send_date(12'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                6'($urandom), 6'($urandom));
    end else begin
      y  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(1995, 2150);
      mo = $urandom_range(1, 12);
      send_date(12'(y), 4'(mo), 5'($urandom_range(1, month_len(mo, y))),
                5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                6'($urandom_range(0, 59)));
    end
  endtask

  task automatic test_epoch_origin;
    send_date(12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(12'd2000, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0);
    send_date(12'd2000, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59);
  endtask

  task automatic test_leap_rules;
    send_date(12'd2000, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0);
    send_date(12'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(12'd2004, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(12'd2100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(12'd2400, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(12'd2001, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    // years before the base add no year days but keep their own leap day
    send_date(12'd1996, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(12'd1900, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
  endtask

  task automatic test_field_extremes;
    send_date(12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_date(12'hFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F);
    send_date(12'd2024, 4'd0, 5'd10, 5'd1, 6'd2, 6'd3);
    send_date(12'd2024, 4'd13, 5'd10, 5'd1, 6'd2, 6'd3);
    send_date(12'd2024, 4'd15, 5'd10, 5'd1, 6'd2, 6'd3);
    send_date(12'd2020, 4'd6, 5'd15, 5'd31, 6'd63, 6'd63);
    send_date(12'd4095, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    // straddle the 2^32 wrap
    send_date(12'd2136, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15);
    send_date(12'd2136, 4'd2, 5'd7, 5'd6, 6'd28, 6'd16);
    send_date(12'd1999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) send_random_date($urandom_range(0, 3) != 0);
  endtask

  task automatic test_drain_pause;
    repeat (40) send_random_date($urandom_range(0, 3) != 0);
    drop_valid();
    wait_drained();
    repeat (40) send_random_date($urandom_range(0, 3) != 0);
  endtask

  task automatic test_steady_stream;
    idle_en = 1'b0;
    repeat (200) send_random_date($urandom_range(0, 3) != 0);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 12) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_result
    logic [31:0] want;
    if (!rst && out_valid && out_ready) begin
      if (epoch_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %0d", $time, epoch_seconds);
      end else begin
        want = epoch_due.pop_front();
        if (epoch_seconds !== want) begin
          mismatches++;
          $display("%0t: epoch_seconds expected %0d actual %0d", $time, want, epoch_seconds);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QuietLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    year         <= '0;
    month        <= '0;
    day          <= '0;
    hour         <= '0;
    minute       <= '0;
    second       <= '0;
    out_ready    <= 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;
    stall_left   = 0;
    idle_en      = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_epoch_origin();
    test_leap_rules();
    test_field_extremes();
    test_random_traffic(780);
    test_drain_pause();
    test_steady_stream();

    drop_valid();
    wait_drained();
    repeat (SettleTail) @(posedge clk);
    if (mismatches == 0 && epoch_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
